// ===== rtl/odlc_pkg.sv =====
`default_nettype none

package odlc_pkg;

    // Configuration port: three registers (32, 16 and 8 bits wide) at byte addresses 0, 4 and 8.
    localparam int CFG_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_IDLE_LIMIT = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LUX_FS     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PROJ_DUTY  = 2'd2;

    localparam logic [31:0] IDLE_LIMIT_RST = 32'd30000;
    localparam logic [15:0] LUX_FS_RST     = 16'd500;
    localparam logic [7:0]  PROJ_DUTY_RST  = 8'd50;

    // Item actions.
    localparam logic [2:0] ACT_SENSE     = 3'd0;
    localparam logic [2:0] ACT_SET_MODE  = 3'd1;
    localparam logic [2:0] ACT_RELAY_ONE = 3'd2;
    localparam logic [2:0] ACT_RELAY_TWO = 3'd3;
    localparam logic [2:0] ACT_BRIGHT    = 3'd4;
    localparam logic [2:0] ACT_ALL_OFF   = 3'd5;

    // Operating modes.
    localparam logic [1:0] CTRL_AUTO      = 2'd0;
    localparam logic [1:0] CTRL_MANUAL    = 2'd1;
    localparam logic [1:0] CTRL_PROJECTOR = 2'd2;
    localparam logic [1:0] CTRL_UNUSED    = 2'd3;

    localparam logic [6:0] PCT_MAX = 7'd100;

    // Serial pass: 32 bit steps for the elapsed-time compare, of which the first
    // 23 also run the restoring divider on the 23-bit product lux*100.
    localparam int SERIAL_STEPS = 32;
    localparam int CNT_W        = 5;
    localparam int DIV_W        = 23;

    localparam logic [CNT_W-1:0] SERIAL_LAST = CNT_W'(SERIAL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_STEPS   = CNT_W'(DIV_W);

    // pct*255/100 for pct in 0..100: multiply by 255*ceil(2^19/100), shift by 19.
    function automatic logic [7:0] pct_to_duty(input logic [6:0] pct);
        logic [31:0] prod;
        prod = 32'(pct) * 32'd1336965;
        return prod[26:19];
    endfunction

    // duty*100/255 for duty in 0..255: multiply by 100*ceil(2^24/255), shift by 24.
    function automatic logic [6:0] duty_to_pct(input logic [7:0] duty);
        logic [31:0] prod;
        prod = 32'(duty) * 32'd6579400;
        return prod[30:24];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/odlc_in_if.sv =====
`default_nettype none

interface odlc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic        pir_active;
    logic        radar_active;
    logic [15:0] lux_reading;
    logic [31:0] now_ms;
    logic [1:0]  new_mode;
    logic        relay_on;
    logic [7:0]  percent_request;

    modport source (
        output valid, action, pir_active, radar_active, lux_reading, now_ms,
               new_mode, relay_on, percent_request,
        input  ready
    );

    modport sink (
        input  valid, action, pir_active, radar_active, lux_reading, now_ms,
               new_mode, relay_on, percent_request,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/odlc_out_if.sv =====
`default_nettype none

interface odlc_out_if;
    logic        valid;
    logic        ready;
    logic        relay_one_on;
    logic        relay_two_on;
    logic [7:0]  dimmer_duty;
    logic [1:0]  mode_now;
    logic [6:0]  brightness_percent;
    logic        presence;
    logic [15:0] lux_seen;

    modport source (
        output valid, relay_one_on, relay_two_on, dimmer_duty, mode_now,
               brightness_percent, presence, lux_seen,
        input  ready
    );

    modport sink (
        input  valid, relay_one_on, relay_two_on, dimmer_duty, mode_now,
               brightness_percent, presence, lux_seen,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/occupancy_daylight_light_controller_unit.sv =====
// Occupancy and daylight lighting controller.
// Items arrive on in_ch (valid/ready); each accepted beat yields exactly one
// result beat on out_ch carrying the relay, duty, mode, presence and lux state
// after the item. Registers for the idle time limit in ms, lux_full_scale and
// projector_duty sit on the APB-style port at byte addresses 0, 4 and 8; they
// may be read back.
// A sense item runs a bit-serial pass (a one-bit-per-cycle borrow chain for the
// elapsed time compare and a 23-step restoring divider for lux*100/full_scale),
// then the state update, then the load of the result register in publish, and
// then goes back to idle. A command item skips the bit-serial pass.
// One item is worked on at a time; the next beat is taken while the previous
// result still waits in the output register.
// If the receiver stalls, a finished item waits until the output register is
// free, and no new beat is taken meanwhile.
// Reset (rst_n low, asynchronous) puts the block in auto mode with relays off,
// duty zero, no presence, and the registers at 30000 ms, 500 lux and duty 50.
`default_nettype none

module occupancy_daylight_light_controller_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [odlc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    odlc_in_if.sink                         in_ch,
    odlc_out_if.source                      out_ch
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SERIAL  = 4'b0010,
        S_APPLY   = 4'b0100,
        S_PUBLISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [31:0] idle_limit_reg;
    logic [15:0] lux_fs_reg;
    logic [7:0]  proj_duty_reg;

    // Controller state.
    logic [1:0]  mode_reg, mode_next;
    logic        relay_one_reg, relay_one_next;
    logic        relay_two_reg, relay_two_next;
    logic [7:0]  duty_reg, duty_next;
    logic        presence_reg, presence_next;
    logic [15:0] lux_reg, lux_next;
    logic [31:0] last_motion_reg, last_motion_next;

    // Latched item.
    logic [2:0]  act_in_reg;
    logic        pir_in_reg;
    logic        radar_in_reg;
    logic [15:0] lux_in_reg;
    logic [1:0]  mode_in_reg;
    logic        relay_in_reg;
    logic [7:0]  pct_in_reg;

    // Serial datapath.
    logic [odlc_pkg::CNT_W-1:0] cnt_reg;
    logic [31:0] now_sh_reg;
    logic [31:0] last_sh_reg;
    logic [31:0] delay_sh_reg;
    logic        borrow_reg;
    logic        gt_reg;
    logic [odlc_pkg::DIV_W-1:0] div_sh_reg;
    logic [15:0] rem_reg;

    // Result register.
    logic        out_valid_reg;
    logic        out_relay_one_reg;
    logic        out_relay_two_reg;
    logic [7:0]  out_duty_reg;
    logic [1:0]  out_mode_reg;
    logic [6:0]  out_pct_reg;
    logic        out_presence_reg;
    logic [15:0] out_lux_reg;

    logic        in_accept;
    logic        cfg_write;
    logic        out_free;
    logic [odlc_pkg::REG_IDX_W-1:0] reg_idx;

    logic        bit_a, bit_b, diff_bit, borrow_next, gt_next;
    logic [15:0] fs_eff;
    logic [16:0] trial;
    logic        fits;
    logic [15:0] rem_next;
    logic [odlc_pkg::DIV_W-1:0] lux_x100;

    logic        sense_pres;
    logic [6:0]  auto_pct;
    logic [6:0]  cmd_pct;

    assign in_accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ch.ready;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[odlc_pkg::CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= odlc_pkg::IDLE_LIMIT_RST;
            lux_fs_reg     <= odlc_pkg::LUX_FS_RST;
            proj_duty_reg  <= odlc_pkg::PROJ_DUTY_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                odlc_pkg::REG_IDLE_LIMIT: idle_limit_reg <= pwdata;
                odlc_pkg::REG_LUX_FS:     lux_fs_reg     <= pwdata[15:0];
                odlc_pkg::REG_PROJ_DUTY:  proj_duty_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            odlc_pkg::REG_IDLE_LIMIT: prdata = idle_limit_reg;
            odlc_pkg::REG_LUX_FS:     prdata = {16'd0, lux_fs_reg};
            odlc_pkg::REG_PROJ_DUTY:  prdata = {24'd0, proj_duty_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (in_ch.action == odlc_pkg::ACT_SENSE) ? S_SERIAL : S_APPLY;
                end
            end
            S_SERIAL:
            begin
                if (cnt_reg == odlc_pkg::SERIAL_LAST)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SERIAL)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Bit-serial datapath.
    // ------------------------------------------------------------------
    // Elapsed time now - last_motion, LSB first, compared against the delay.
    // The last differing bit decides which of the two is greater.
    assign bit_a       = now_sh_reg[0];
    assign bit_b       = last_sh_reg[0];
    assign diff_bit    = bit_a ^ bit_b ^ borrow_reg;
    assign borrow_next = (~bit_a & bit_b) | (~(bit_a ^ bit_b) & borrow_reg);
    assign gt_next     = (diff_bit != delay_sh_reg[0]) ? diff_bit : gt_reg;

    // Restoring divider, one quotient bit per cycle; a zero full scale acts as one.
    assign fs_eff   = (lux_fs_reg == 16'd0) ? 16'd1 : lux_fs_reg;
    assign trial    = {rem_reg, div_sh_reg[odlc_pkg::DIV_W-1]};
    assign fits     = (trial >= {1'b0, fs_eff});
    assign rem_next = fits ? 16'(trial - {1'b0, fs_eff}) : trial[15:0];
    assign lux_x100 = odlc_pkg::DIV_W'(in_ch.lux_reading) * odlc_pkg::DIV_W'(100);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_in_reg   <= in_ch.action;
            pir_in_reg   <= in_ch.pir_active;
            radar_in_reg <= in_ch.radar_active;
            lux_in_reg   <= in_ch.lux_reading;
            mode_in_reg  <= in_ch.new_mode;
            relay_in_reg <= in_ch.relay_on;
            pct_in_reg   <= in_ch.percent_request;
            now_sh_reg   <= in_ch.now_ms;
            last_sh_reg  <= last_motion_reg;
            delay_sh_reg <= idle_limit_reg;
            borrow_reg   <= 1'b0;
            gt_reg       <= 1'b0;
            div_sh_reg   <= lux_x100;
            rem_reg      <= 16'd0;
        end
        else if (state_reg == S_SERIAL)
        begin
            // The timestamp rotates so that it is whole again after the pass.
            now_sh_reg   <= {now_sh_reg[0], now_sh_reg[31:1]};
            last_sh_reg  <= {1'b0, last_sh_reg[31:1]};
            delay_sh_reg <= {1'b0, delay_sh_reg[31:1]};
            borrow_reg   <= borrow_next;
            gt_reg       <= gt_next;
            if (cnt_reg < odlc_pkg::DIV_STEPS)
            begin
                div_sh_reg <= {div_sh_reg[odlc_pkg::DIV_W-2:0], fits};
                rem_reg    <= rem_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // State update.
    // ------------------------------------------------------------------
    assign sense_pres = pir_in_reg | radar_in_reg;
    assign auto_pct   = (div_sh_reg >= odlc_pkg::DIV_W'(odlc_pkg::PCT_MAX)) ? 7'd0
                        : 7'(odlc_pkg::PCT_MAX - div_sh_reg[6:0]);
    assign cmd_pct    = (pct_in_reg > 8'(odlc_pkg::PCT_MAX)) ? odlc_pkg::PCT_MAX
                        : pct_in_reg[6:0];

    always_comb
    begin
        mode_next        = mode_reg;
        relay_one_next   = relay_one_reg;
        relay_two_next   = relay_two_reg;
        duty_next        = duty_reg;
        presence_next    = presence_reg;
        lux_next         = lux_reg;
        last_motion_next = last_motion_reg;
        if (state_reg == S_APPLY)
        begin
            unique case (act_in_reg)
                odlc_pkg::ACT_SENSE:
                begin
                    presence_next = sense_pres;
                    lux_next      = lux_in_reg;
                    if (sense_pres)
                    begin
                        last_motion_next = now_sh_reg;
                    end
                    priority if (mode_reg == odlc_pkg::CTRL_PROJECTOR)
                    begin
                        relay_one_next = 1'b0;
                        relay_two_next = 1'b0;
                        duty_next      = proj_duty_reg;
                    end
                    else if (mode_reg == odlc_pkg::CTRL_AUTO)
                    begin
                        if (sense_pres)
                        begin
                            relay_one_next = 1'b1;
                            relay_two_next = 1'b1;
                            duty_next      = odlc_pkg::pct_to_duty(auto_pct);
                        end
                        else if (gt_reg)
                        begin
                            relay_one_next = 1'b0;
                            relay_two_next = 1'b0;
                            duty_next      = 8'd0;
                        end
                    end
                    else
                    begin
                        // Manual and the unused mode code leave the outputs alone.
                    end
                end
                odlc_pkg::ACT_SET_MODE:
                begin
                    if (mode_in_reg != odlc_pkg::CTRL_UNUSED)
                    begin
                        mode_next = mode_in_reg;
                    end
                end
                odlc_pkg::ACT_RELAY_ONE:
                begin
                    mode_next      = odlc_pkg::CTRL_MANUAL;
                    relay_one_next = relay_in_reg;
                end
                odlc_pkg::ACT_RELAY_TWO:
                begin
                    mode_next      = odlc_pkg::CTRL_MANUAL;
                    relay_two_next = relay_in_reg;
                end
                odlc_pkg::ACT_BRIGHT:
                begin
                    mode_next = odlc_pkg::CTRL_MANUAL;
                    duty_next = odlc_pkg::pct_to_duty(cmd_pct);
                end
                odlc_pkg::ACT_ALL_OFF:
                begin
                    relay_one_next = 1'b0;
                    relay_two_next = 1'b0;
                    duty_next      = 8'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= odlc_pkg::CTRL_AUTO;
            relay_one_reg   <= 1'b0;
            relay_two_reg   <= 1'b0;
            duty_reg        <= 8'd0;
            presence_reg    <= 1'b0;
            lux_reg         <= 16'd0;
            last_motion_reg <= 32'd0;
        end
        else
        begin
            mode_reg        <= mode_next;
            relay_one_reg   <= relay_one_next;
            relay_two_reg   <= relay_two_next;
            duty_reg        <= duty_next;
            presence_reg    <= presence_next;
            lux_reg         <= lux_next;
            last_motion_reg <= last_motion_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_PUBLISH && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PUBLISH && out_free)
        begin
            out_relay_one_reg <= relay_one_reg;
            out_relay_two_reg <= relay_two_reg;
            out_duty_reg      <= duty_reg;
            out_mode_reg      <= mode_reg;
            out_pct_reg       <= odlc_pkg::duty_to_pct(duty_reg);
            out_presence_reg  <= presence_reg;
            out_lux_reg       <= lux_reg;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.relay_one_on       = out_relay_one_reg;
    assign out_ch.relay_two_on       = out_relay_two_reg;
    assign out_ch.dimmer_duty        = out_duty_reg;
    assign out_ch.mode_now           = out_mode_reg;
    assign out_ch.brightness_percent = out_pct_reg;
    assign out_ch.presence           = out_presence_reg;
    assign out_ch.lux_seen           = out_lux_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ch.ready)
        else $error("input taken while an item is still in work");

    a_serial_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SERIAL && cnt_reg == odlc_pkg::SERIAL_LAST) |=> state_reg == S_APPLY)
        else $error("serial pass did not end after its last step");

    a_apply_publish: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |=> state_reg == S_PUBLISH)
        else $error("state update not followed by publish");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUBLISH && out_valid_reg && !out_ch.ready) |=> state_reg == S_PUBLISH)
        else $error("result published over a pending beat");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_pct_reg <= odlc_pkg::PCT_MAX)
        else $error("brightness percent above 100");

endmodule

`default_nettype wire

// ===== tb/odlc_light_checker.sv =====
`default_nettype none

module odlc_light_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    odlc_in_if                              in_mon,
    odlc_out_if                             out_mon,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [odlc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        relay_one;
        logic        relay_two;
        logic [7:0]  duty;
        logic [1:0]  mode;
        logic [6:0]  percent;
        logic        presence;
        logic [15:0] lux;
    } lamp_state_t;

    // Register copies.
    logic [31:0] idle_limit;
    logic [15:0] full_scale;
    logic [7:0]  proj_duty;

    // Controller state as the block should hold it.
    logic [1:0]  mode_q;
    logic        relay_one_q;
    logic        relay_two_q;
    logic [7:0]  duty_q;
    logic        presence_q;
    logic [15:0] lux_q;
    logic [31:0] motion_ms_q;

    lamp_state_t lamp_expected_q[$];
    int          mismatch_cnt = 0;

    function automatic logic [7:0] scale_percent(int unsigned pct);
        return 8'((pct * 255) / 100);
    endfunction

    function automatic string show_lamp(lamp_state_t s);
        return $sformatf("r1=%0d r2=%0d duty=%0d mode=%0d pct=%0d pres=%0d lux=%0d",
                         s.relay_one, s.relay_two, s.duty, s.mode, s.percent,
                         s.presence, s.lux);
    endfunction

    task automatic predict_lamp_state();
        logic [31:0] elapsed;
        int unsigned fs;
        int unsigned ratio;
        int unsigned pct;
        lamp_state_t nxt;
        case (in_mon.action)
            odlc_pkg::ACT_SENSE:
            begin
                presence_q = in_mon.pir_active | in_mon.radar_active;
                if (presence_q)
                    motion_ms_q = in_mon.now_ms;
                lux_q = in_mon.lux_reading;
                if (mode_q == odlc_pkg::CTRL_PROJECTOR)
                begin
                    relay_one_q = 1'b0;
                    relay_two_q = 1'b0;
                    duty_q      = proj_duty;
                end
                else if (mode_q == odlc_pkg::CTRL_AUTO)
                begin
                    elapsed = in_mon.now_ms - motion_ms_q;
                    if (!presence_q && elapsed > idle_limit)
                    begin
                        duty_q      = '0;
                        relay_one_q = 1'b0;
                        relay_two_q = 1'b0;
                    end
                    else if (presence_q)
                    begin
                        // A full scale of zero divides as one.
                        fs    = (full_scale == 0) ? 1 : full_scale;
                        ratio = (int'(lux_q) * 100) / fs;
                        pct   = (ratio >= 100) ? 0 : 100 - ratio;
                        relay_one_q = 1'b1;
                        relay_two_q = 1'b1;
                        duty_q      = scale_percent(pct);
                    end
                end
            end
            odlc_pkg::ACT_SET_MODE:
            begin
                if (in_mon.new_mode != odlc_pkg::CTRL_UNUSED)
                    mode_q = in_mon.new_mode;
            end
            odlc_pkg::ACT_RELAY_ONE:
            begin
                mode_q      = odlc_pkg::CTRL_MANUAL;
                relay_one_q = in_mon.relay_on;
            end
            odlc_pkg::ACT_RELAY_TWO:
            begin
                mode_q      = odlc_pkg::CTRL_MANUAL;
                relay_two_q = in_mon.relay_on;
            end
            odlc_pkg::ACT_BRIGHT:
            begin
                mode_q = odlc_pkg::CTRL_MANUAL;
                pct    = (in_mon.percent_request > odlc_pkg::PCT_MAX) ? odlc_pkg::PCT_MAX
                         : in_mon.percent_request;
                duty_q = scale_percent(pct);
            end
            odlc_pkg::ACT_ALL_OFF:
            begin
                duty_q      = '0;
                relay_one_q = 1'b0;
                relay_two_q = 1'b0;
            end
            default:
            begin
            end
        endcase
        nxt.relay_one = relay_one_q;
        nxt.relay_two = relay_two_q;
        nxt.duty      = duty_q;
        nxt.mode      = mode_q;
        nxt.percent   = 7'((int'(duty_q) * 100) / 255);
        nxt.presence  = presence_q;
        nxt.lux       = lux_q;
        lamp_expected_q.push_back(nxt);
    endtask

    task automatic check_lamp_result();
        lamp_state_t got;
        lamp_state_t want;
        got.relay_one = out_mon.relay_one_on;
        got.relay_two = out_mon.relay_two_on;
        got.duty      = out_mon.dimmer_duty;
        got.mode      = out_mon.mode_now;
        got.percent   = out_mon.brightness_percent;
        got.presence  = out_mon.presence;
        got.lux       = out_mon.lux_seen;
        if (lamp_expected_q.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: result beat with nothing expected: %s", $time, show_lamp(got));
        end
        else
        begin
            want = lamp_expected_q.pop_front();
            if (got !== want)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                             $time, show_lamp(want), show_lamp(got));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit  = odlc_pkg::IDLE_LIMIT_RST;
            full_scale  = odlc_pkg::LUX_FS_RST;
            proj_duty   = odlc_pkg::PROJ_DUTY_RST;
            mode_q      = odlc_pkg::CTRL_AUTO;
            relay_one_q = 1'b0;
            relay_two_q = 1'b0;
            duty_q      = '0;
            presence_q  = 1'b0;
            lux_q       = '0;
            motion_ms_q = '0;
            lamp_expected_q.delete();
            errors  <= mismatch_cnt;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[odlc_pkg::CFG_ADDR_W-1:2])
                    odlc_pkg::REG_IDLE_LIMIT: idle_limit = pwdata;
                    odlc_pkg::REG_LUX_FS:     full_scale = pwdata[15:0];
                    odlc_pkg::REG_PROJ_DUTY:  proj_duty  = pwdata[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                predict_lamp_state();
            if (out_mon.valid && out_mon.ready)
                check_lamp_result();
            errors  <= mismatch_cnt;
            pending <= lamp_expected_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_occupancy_daylight_light_controller_unit.sv =====
`default_nettype none

module tb_occupancy_daylight_light_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          HOLD_LEN    = 400;
    localparam int          PHASE_ITEMS = 75;

    // Actions the block accepts but does nothing with.
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    typedef struct {
        logic [2:0]  action;
        logic        pir;
        logic        radar;
        logic [15:0] lux;
        logic [31:0] now;
        logic [1:0]  new_mode;
        logic        relay_on;
        logic [7:0]  pct_req;
    } light_cmd_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [odlc_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    odlc_in_if  in_ch();
    odlc_out_if out_ch();

    int          errors;
    int          pending;
    int unsigned cycles = 0;
    logic        no_idle = 1'b0;
    int          hold_reqs = 0;
    int          hold_served = 0;
    int          hold_left = 0;

    logic [31:0] clock_ms = '0;
    logic [31:0] motion_ms = '0;
    logic [31:0] cur_delay = odlc_pkg::IDLE_LIMIT_RST;
    logic [15:0] cur_fs = odlc_pkg::LUX_FS_RST;

    occupancy_daylight_light_controller_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    odlc_light_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_mon  (in_ch),
        .out_mon (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .errors  (errors),
        .pending (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (hold_served != hold_reqs)
        begin
            hold_served  <= hold_served + 1;
            hold_left    <= HOLD_LEN;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= no_idle || ($urandom_range(99) >= 35);
    end

    function automatic light_cmd_t random_fields();
        light_cmd_t c;
        c.action   = odlc_pkg::ACT_SENSE;
        c.pir      = 1'($urandom);
        c.radar    = 1'($urandom);
        c.lux      = 16'($urandom);
        c.now      = clock_ms;
        c.new_mode = 2'($urandom);
        c.relay_on = 1'($urandom);
        c.pct_req  = 8'($urandom);
        return c;
    endfunction

    // Holds valid high across back-to-back beats; it only drops for a gap.
    task automatic send_item(light_cmd_t c);
        while (!no_idle && $urandom_range(99) < 35)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.action          <= c.action;
        in_ch.pir_active      <= c.pir;
        in_ch.radar_active    <= c.radar;
        in_ch.lux_reading     <= c.lux;
        in_ch.now_ms          <= c.now;
        in_ch.new_mode        <= c.new_mode;
        in_ch.relay_on        <= c.relay_on;
        in_ch.percent_request <= c.pct_req;
        if (c.action == odlc_pkg::ACT_SENSE)
        begin
            clock_ms = c.now;
            if (c.pir || c.radar)
                motion_ms = c.now;
        end
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_sense(logic pir, logic radar, logic [15:0] lux, logic [31:0] now);
        light_cmd_t c;
        c       = random_fields();
        c.pir   = pir;
        c.radar = radar;
        c.lux   = lux;
        c.now   = now;
        send_item(c);
    endtask

    task automatic send_cmd(logic [2:0] action, logic [1:0] new_mode, logic relay_on,
                            logic [7:0] pct_req);
        light_cmd_t c;
        c          = random_fields();
        c.action   = action;
        c.new_mode = new_mode;
        c.relay_on = relay_on;
        c.pct_req  = pct_req;
        send_item(c);
    endtask

    task automatic wait_results_done();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [odlc_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [31:0] delay, logic [15:0] fs, logic [7:0] pduty);
        wait_results_done();
        write_reg(odlc_pkg::REG_IDLE_LIMIT, delay);
        write_reg(odlc_pkg::REG_LUX_FS, {16'h0, fs});
        write_reg(odlc_pkg::REG_PROJ_DUTY, {24'h0, pduty});
        cur_delay = delay;
        cur_fs    = fs;
    endtask

    task automatic send_random_item();
        light_cmd_t  c;
        int unsigned pick;
        int unsigned lux_span;
        int unsigned reach;
        c    = random_fields();
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            c.action = odlc_pkg::ACT_SENSE;
            c.pir    = ($urandom_range(99) < 35);
            c.radar  = ($urandom_range(99) < 35);
            lux_span = (cur_fs == 0) ? 2 : (int'(cur_fs) * 11) / 10 + 1;
            if (lux_span > 65535)
                lux_span = 65535;
            if ($urandom_range(1) == 0)
                c.lux = 16'($urandom_range(lux_span));
            reach = (cur_delay > 100000) ? 100000 : cur_delay;
            pick  = $urandom_range(99);
            // Mostly small steps in time; sometimes right at the off threshold.
            if (pick < 3)
                c.now = $urandom();
            else if (pick < 13 && !c.pir && !c.radar)
                c.now = motion_ms + cur_delay + 32'($urandom_range(1));
            else if (pick < 28)
                c.now = clock_ms + $urandom_range(2 * reach + 10);
            else
                c.now = clock_ms + $urandom_range(300);
        end
        else if (pick < 65)
        begin
            c.action   = odlc_pkg::ACT_SET_MODE;
            c.new_mode = ($urandom_range(99) < 50) ? odlc_pkg::CTRL_AUTO
                         : 2'($urandom_range(3));
        end
        else if (pick < 71)
            c.action = odlc_pkg::ACT_RELAY_ONE;
        else if (pick < 77)
            c.action = odlc_pkg::ACT_RELAY_TWO;
        else if (pick < 85)
            c.action = odlc_pkg::ACT_BRIGHT;
        else if (pick < 93)
            c.action = odlc_pkg::ACT_ALL_OFF;
        else
            c.action = ($urandom_range(1) == 0) ? ACT_SPARE_A : ACT_SPARE_B;
        send_item(c);
    endtask

    initial
    begin
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_ch.valid           = 1'b0;
        in_ch.action          = odlc_pkg::ACT_SENSE;
        in_ch.pir_active      = 1'b0;
        in_ch.radar_active    = 1'b0;
        in_ch.lux_reading     = '0;
        in_ch.now_ms          = '0;
        in_ch.new_mode        = odlc_pkg::CTRL_AUTO;
        in_ch.relay_on        = 1'b0;
        in_ch.percent_request = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, register values as after reset.
        send_sense(1'b1, 1'b0, 16'd0, 32'd1000);
        send_sense(1'b0, 1'b1, 16'hFFFF, 32'd2000);
        send_sense(1'b1, 1'b1, 16'd250, 32'd3000);
        // No motion for exactly the delay keeps the lights; one more ms turns them off.
        send_sense(1'b0, 1'b0, 16'd100, 32'd33000);
        send_sense(1'b0, 1'b0, 16'h5555, 32'd33001);
        send_cmd(odlc_pkg::ACT_SET_MODE, odlc_pkg::CTRL_PROJECTOR, 1'b0, 8'd0);
        send_sense(1'b1, 1'b0, 16'd10, 32'd34000);
        send_cmd(odlc_pkg::ACT_SET_MODE, odlc_pkg::CTRL_UNUSED, 1'b1, 8'd0);
        send_sense(1'b0, 1'b0, 16'd20, 32'd99000);
        send_cmd(odlc_pkg::ACT_SET_MODE, odlc_pkg::CTRL_MANUAL, 1'b0, 8'd0);
        send_sense(1'b1, 1'b1, 16'd30, 32'd100000);
        send_cmd(odlc_pkg::ACT_RELAY_ONE, odlc_pkg::CTRL_AUTO, 1'b1, 8'd0);
        send_cmd(odlc_pkg::ACT_RELAY_TWO, odlc_pkg::CTRL_AUTO, 1'b1, 8'd0);
        send_cmd(odlc_pkg::ACT_RELAY_ONE, odlc_pkg::CTRL_AUTO, 1'b0, 8'd0);
        send_cmd(odlc_pkg::ACT_BRIGHT, odlc_pkg::CTRL_AUTO, 1'b0, 8'd0);
        send_cmd(odlc_pkg::ACT_BRIGHT, odlc_pkg::CTRL_AUTO, 1'b0, 8'd100);
        send_cmd(odlc_pkg::ACT_BRIGHT, odlc_pkg::CTRL_AUTO, 1'b0, 8'd101);
        send_cmd(odlc_pkg::ACT_BRIGHT, odlc_pkg::CTRL_AUTO, 1'b0, 8'd255);
        send_cmd(odlc_pkg::ACT_ALL_OFF, odlc_pkg::CTRL_AUTO, 1'b1, 8'd50);
        send_cmd(ACT_SPARE_A, odlc_pkg::CTRL_AUTO, 1'b1, 8'd50);
        send_cmd(ACT_SPARE_B, odlc_pkg::CTRL_PROJECTOR, 1'b1, 8'd50);
        send_cmd(odlc_pkg::ACT_SET_MODE, odlc_pkg::CTRL_AUTO, 1'b0, 8'd0);
        // Lux at full scale gives zero duty; elapsed time wraps past zero.
        send_sense(1'b1, 1'b0, 16'd500, 32'hFFFF_FF00);
        send_sense(1'b0, 1'b0, 16'd499, 32'h0000_0100);
        send_sense(1'b0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: configure(32'd0, 16'd1, 8'd0);
                1: configure(32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
                2: configure(32'd500, 16'd500, 8'd50);
                3: configure(32'd2000, 16'd0, 8'h80);
                4: configure(32'($urandom_range(100, 5000)), 16'($urandom_range(1, 65535)),
                             8'($urandom_range(255)));
                default: configure(32'd30000, 16'd1000, 8'h7F);
            endcase
            no_idle <= (phase == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 3 && i == 10)
                    hold_reqs <= hold_reqs + 1;
                if (phase == 4 && i == 40)
                    wait_results_done();
                send_random_item();
            end
        end

        wait_results_done();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
